FILE: rtl/prsg_pkg.sv
package prsg_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Shared multiplier: 32-bit operand A times 20-bit operand B
    // (judged elapsed time is at most 10 * 65535 < 2^20)
    localparam int unsigned MUL_A_W  = 32;
    localparam int unsigned MUL_B_W  = 20;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DETACH   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REATTACH = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES   = 2'd2;

    // Register reset values
    localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = 16'd100;
    localparam logic [TIME_W-1:0]  QUIET_TIME_RST    = 32'd1000;
    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST   = 32'd1000;

    localparam logic [COUNT_W-1:0] TALLY_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_A,
        ST_MUL_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } mul_req_t;

endpackage

FILE: rtl/prsg_mul.sv
// Bit-serial shift-add multiplier, one bit of B per cycle.
module prsg_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  prsg_pkg::mul_req_t              req,
    output logic                            done,
    output logic [prsg_pkg::PROD_W-1:0]     product
);

    logic [prsg_pkg::PROD_W-1:0]    a_sh_reg, a_sh_next;
    logic [prsg_pkg::MUL_B_W-1:0]   b_reg, b_next;
    logic [prsg_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [prsg_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    always_comb
    begin
        a_sh_next = a_sh_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_sh_next = {{(prsg_pkg::PROD_W - prsg_pkg::MUL_A_W){1'b0}}, req.a};
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_sh_reg;
            a_sh_next = a_sh_reg << 1;
            b_next    = b_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == prsg_pkg::MUL_CNT_W'(prsg_pkg::MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("multiplier not busy after start");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("multiplier done without a run");
`endif

endmodule

FILE: rtl/pulse_rate_storm_guard.sv
// A judged window runs two multiplies in turn on the shared shift-add unit, first
// max_entries * elapsed and then delta * win, before its result is registered; any other
// poll goes from evaluation straight to the result register. in_ready is high only
// while the sequencer is idle, so a new poll waits until the last one has left the
// sequencer; the result register lets the next poll in while a result waits for transfer.
// Reset (rst_n, async, active low): unseeded, not faulted, counters and judged delta zero.
module pulse_rate_storm_guard (
    input  logic                               clk,
    input  logic                               rst_n,
    // poll channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [prsg_pkg::TIME_W-1:0]        now_ms,
    input  logic [prsg_pkg::COUNT_W-1:0]       entry_count,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [prsg_pkg::ACT_W-1:0]         action,
    output logic [prsg_pkg::COUNT_W-1:0]       faults_seen,
    output logic [prsg_pkg::COUNT_W-1:0]       last_judged_entries,
    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; index 3 is dropped.
    // ------------------------------------------------------------------
    logic [prsg_pkg::WIN_W-1:0]   win_len_reg;
    logic [prsg_pkg::TIME_W-1:0]  quiet_reg;
    logic [prsg_pkg::COUNT_W-1:0] max_ent_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= prsg_pkg::WINDOW_LENGTH_RST;
            quiet_reg   <= prsg_pkg::QUIET_TIME_RST;
            max_ent_reg <= prsg_pkg::MAX_ENTRIES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                prsg_pkg::CFG_WINDOW_LENGTH: win_len_reg <= cfg_data[prsg_pkg::WIN_W-1:0];
                prsg_pkg::CFG_QUIET_TIME:    quiet_reg   <= cfg_data;
                prsg_pkg::CFG_MAX_ENTRIES:   max_ent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    prsg_pkg::state_t state_reg, state_next;

    logic                           seeded_reg, seeded_next;
    logic                           in_fault_reg, in_fault_next;
    logic [prsg_pkg::TIME_W-1:0]    win_time_reg, win_time_next;
    logic [prsg_pkg::COUNT_W-1:0]   win_count_reg, win_count_next;
    logic [prsg_pkg::TIME_W-1:0]    fault_time_reg, fault_time_next;
    logic [prsg_pkg::COUNT_W-1:0]   tally_reg, tally_next;
    logic [prsg_pkg::COUNT_W-1:0]   judged_reg, judged_next;
    logic [prsg_pkg::ACT_W-1:0]     act_reg, act_next;
    logic [prsg_pkg::TIME_W-1:0]    now_reg;
    logic [prsg_pkg::COUNT_W-1:0]   count_reg;
    logic [prsg_pkg::PROD_W-1:0]    limit_reg;      // max_entries * elapsed

    logic                           out_valid_reg, out_valid_next;
    logic [prsg_pkg::ACT_W-1:0]     action_reg;
    logic [prsg_pkg::COUNT_W-1:0]   faults_reg;
    logic [prsg_pkg::COUNT_W-1:0]   last_judged_reg;

    // ------------------------------------------------------------------
    // Window arithmetic on the latched poll
    // ------------------------------------------------------------------
    logic [prsg_pkg::WIN_W-1:0]     win;            // zero length reads as 1 ms
    logic [prsg_pkg::MUL_B_W-1:0]   win_ext;
    logic [prsg_pkg::MUL_B_W-1:0]   stall_limit;    // 10 * win
    logic [prsg_pkg::TIME_W-1:0]    elapsed;
    logic [prsg_pkg::TIME_W-1:0]    quiet_elapsed;
    logic [prsg_pkg::COUNT_W-1:0]   delta;
    logic                           quiet_over;
    logic                           window_done;
    logic                           stalled;
    logic                           judge;
    logic                           over_limit;

    assign win           = (win_len_reg == '0) ? prsg_pkg::WIN_W'(1) : win_len_reg;
    assign win_ext       = prsg_pkg::MUL_B_W'(win);
    assign stall_limit   = (win_ext << 3) + (win_ext << 1);
    assign elapsed       = now_reg - win_time_reg;
    assign quiet_elapsed = now_reg - fault_time_reg;
    assign delta         = count_reg - win_count_reg;
    assign quiet_over    = !(quiet_elapsed < quiet_reg);
    assign window_done   = !(elapsed < prsg_pkg::TIME_W'(win));
    assign stalled       = elapsed > prsg_pkg::TIME_W'(stall_limit);
    assign judge         = seeded_reg && !in_fault_reg && window_done && !stalled;

    // ------------------------------------------------------------------
    // Shared multiplier. The verdict delta > floor(max * elapsed / win) is the
    // same as max * elapsed < delta * win, so two multiplies replace a divide.
    // ------------------------------------------------------------------
    prsg_pkg::mul_req_t             mul_req;
    logic                           mul_done;
    logic [prsg_pkg::PROD_W-1:0]    mul_product;

    prsg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    assign over_limit = limit_reg < mul_product;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prsg_pkg::ST_IDLE:
                if (in_valid)
                    state_next = prsg_pkg::ST_EVAL;
            prsg_pkg::ST_EVAL:
                state_next = judge ? prsg_pkg::ST_MUL_A : prsg_pkg::ST_DONE;
            prsg_pkg::ST_MUL_A:
                if (mul_done)
                    state_next = prsg_pkg::ST_MUL_B;
            prsg_pkg::ST_MUL_B:
                if (mul_done)
                    state_next = prsg_pkg::ST_DONE;
            prsg_pkg::ST_DONE:
                if (out_free)
                    state_next = prsg_pkg::ST_IDLE;
            default:
                state_next = prsg_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (handshake and multiplier requests)
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready      = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = max_ent_reg;
        mul_req.b     = elapsed[prsg_pkg::MUL_B_W-1:0];
        unique case (state_reg)
            prsg_pkg::ST_IDLE:
                in_ready = 1'b1;
            prsg_pkg::ST_EVAL:
                mul_req.start = judge;      // max_entries * elapsed
            prsg_pkg::ST_MUL_A:
            begin
                mul_req.start = mul_done;   // delta * win
                mul_req.a     = judged_reg;
                mul_req.b     = win_ext;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Detector state updates
    // ------------------------------------------------------------------
    always_comb
    begin
        seeded_next     = seeded_reg;
        in_fault_next   = in_fault_reg;
        win_time_next   = win_time_reg;
        win_count_next  = win_count_reg;
        fault_time_next = fault_time_reg;
        tally_next      = tally_reg;
        judged_next     = judged_reg;
        act_next        = act_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            prsg_pkg::ST_EVAL:
            begin
                act_next = prsg_pkg::ACT_NONE;
                if (!seeded_reg)
                begin
                    // first poll only seeds the window
                    seeded_next    = 1'b1;
                    win_time_next  = now_reg;
                    win_count_next = count_reg;
                end
                else if (in_fault_reg)
                begin
                    if (quiet_over)
                    begin
                        in_fault_next  = 1'b0;
                        win_time_next  = now_reg;
                        win_count_next = count_reg;
                        act_next       = prsg_pkg::ACT_REATTACH;
                    end
                end
                else if (window_done)
                begin
                    // window restarts whether or not it is judged
                    win_time_next  = now_reg;
                    win_count_next = count_reg;
                    if (!stalled)
                        judged_next = delta;
                end
            end
            prsg_pkg::ST_MUL_B:
                if (mul_done && over_limit)
                begin
                    in_fault_next   = 1'b1;
                    fault_time_next = now_reg;
                    act_next        = prsg_pkg::ACT_DETACH;
                    if (tally_reg != prsg_pkg::TALLY_MAX)
                        tally_next = tally_reg + 1'b1;
                end
            prsg_pkg::ST_DONE:
                if (out_free)
                    out_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prsg_pkg::ST_IDLE;
            seeded_reg     <= 1'b0;
            in_fault_reg   <= 1'b0;
            win_time_reg   <= '0;
            win_count_reg  <= '0;
            fault_time_reg <= '0;
            tally_reg      <= '0;
            judged_reg     <= '0;
            act_reg        <= prsg_pkg::ACT_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seeded_reg     <= seeded_next;
            in_fault_reg   <= in_fault_next;
            win_time_reg   <= win_time_next;
            win_count_reg  <= win_count_next;
            fault_time_reg <= fault_time_next;
            tally_reg      <= tally_next;
            judged_reg     <= judged_next;
            act_reg        <= act_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: poll capture, first product, result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg   <= now_ms;
            count_reg <= entry_count;
        end
        if (state_reg == prsg_pkg::ST_MUL_A && mul_done)
            limit_reg <= mul_product;
        if (state_reg == prsg_pkg::ST_DONE && out_free)
        begin
            action_reg      <= act_reg;
            faults_reg      <= tally_reg;
            last_judged_reg <= judged_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign action              = action_reg;
    assign faults_seen         = faults_reg;
    assign last_judged_entries = last_judged_reg;

`ifndef SYNTHESIS
    a_poll_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == prsg_pkg::ST_EVAL)
        else $error("accepted poll did not start evaluation");
    a_start_states: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> (state_reg == prsg_pkg::ST_EVAL || state_reg == prsg_pkg::ST_MUL_A))
        else $error("multiplier started outside the judging sequence");
    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(tally_reg < $past(tally_reg)))
        else $error("fault tally decreased");
    a_detach_faulted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prsg_pkg::ST_DONE && act_reg == prsg_pkg::ACT_DETACH) |-> in_fault_reg)
        else $error("detach without fault state");
`endif

endmodule

FILE: dv/tb_pulse_rate_storm_guard.sv
module tb_pulse_rate_storm_guard;

    // the block throws away a window longer than this many nominal windows
    localparam int unsigned WINDOW_STALL_FACTOR = 10;
    // index 3 decodes to no register; a write there must change nothing
    localparam logic [prsg_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int unsigned REPORT_LIMIT = 10;
    // long receiver hold-off, so the poll side backs up behind the result register
    localparam int unsigned RECEIVER_HOLD_CYCLES = 400;
    // margin that covers any poll still in flight
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned WATCHDOG_CYCLES = 3000;

    typedef struct packed {
        logic [prsg_pkg::ACT_W-1:0]   act;
        logic [prsg_pkg::COUNT_W-1:0] faults;
        logic [prsg_pkg::COUNT_W-1:0] judged;
    } verdict_t;

    // Rate guard predictor plus the queue of verdicts still owed by the block.
    class storm_verdict_board;
        verdict_t                     verdicts_due[$];
        int unsigned                  mismatches;
        int unsigned                  results_seen;
        // register copies
        logic [prsg_pkg::WIN_W-1:0]   win_len;
        logic [prsg_pkg::TIME_W-1:0]  quiet_ms;
        logic [prsg_pkg::COUNT_W-1:0] max_per_win;
        // guard state
        bit                           seeded;
        bit                           faulted;
        logic [prsg_pkg::TIME_W-1:0]  win_t0;
        logic [prsg_pkg::COUNT_W-1:0] win_n0;
        logic [prsg_pkg::TIME_W-1:0]  fault_t0;
        logic [prsg_pkg::COUNT_W-1:0] fault_tally;
        logic [prsg_pkg::COUNT_W-1:0] judged;

        function new();
            win_len     = prsg_pkg::WINDOW_LENGTH_RST;
            quiet_ms    = prsg_pkg::QUIET_TIME_RST;
            max_per_win = prsg_pkg::MAX_ENTRIES_RST;
            seeded      = 1'b0;
            faulted     = 1'b0;
            win_t0      = '0;
            win_n0      = '0;
            fault_t0    = '0;
            fault_tally = '0;
            judged      = '0;
            mismatches  = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [prsg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                prsg_pkg::CFG_WINDOW_LENGTH: win_len = data[prsg_pkg::WIN_W-1:0];
                prsg_pkg::CFG_QUIET_TIME:    quiet_ms = data;
                prsg_pkg::CFG_MAX_ENTRIES:   max_per_win = data;
                default: ;
            endcase
        endfunction

        function void take_poll(logic [prsg_pkg::TIME_W-1:0] t,
                                logic [prsg_pkg::COUNT_W-1:0] n);
            logic [prsg_pkg::TIME_W-1:0]  win;
            logic [prsg_pkg::TIME_W-1:0]  elapsed;
            logic [prsg_pkg::TIME_W-1:0]  cooled;
            logic [prsg_pkg::COUNT_W-1:0] delta;
            logic [63:0]                  allowed;
            verdict_t                     v;
            // zero length behaves as a 1 ms window
            win = (win_len == '0) ? 32'd1 : {16'd0, win_len};
            v.act = prsg_pkg::ACT_NONE;
            if (!seeded)
            begin
                seeded = 1'b1;
                win_t0 = t;
                win_n0 = n;
            end
            else if (faulted)
            begin
                cooled = t - fault_t0;
                if (cooled >= quiet_ms)
                begin
                    faulted = 1'b0;
                    win_t0  = t;
                    win_n0  = n;
                    v.act   = prsg_pkg::ACT_REATTACH;
                end
            end
            else
            begin
                elapsed = t - win_t0;
                if (elapsed >= win)
                begin
                    delta  = n - win_n0;
                    win_t0 = t;
                    win_n0 = n;
                    // overlong window restarts without touching the judged delta
                    if (elapsed <= WINDOW_STALL_FACTOR * win)
                    begin
                        judged  = delta;
                        allowed = (64'(max_per_win) * 64'(elapsed)) / 64'(win);
                        if (64'(delta) > allowed)
                        begin
                            faulted  = 1'b1;
                            fault_t0 = t;
                            if (fault_tally != prsg_pkg::TALLY_MAX)
                                fault_tally++;
                            v.act = prsg_pkg::ACT_DETACH;
                        end
                    end
                end
            end
            v.faults = fault_tally;
            v.judged = judged;
            verdicts_due.push_back(v);
        endfunction

        function void judge_result(logic [prsg_pkg::ACT_W-1:0] act,
                                   logic [prsg_pkg::COUNT_W-1:0] faults,
                                   logic [prsg_pkg::COUNT_W-1:0] judged_out);
            verdict_t v;
            results_seen++;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d with no poll pending: action %0d faults %0d judged %0d",
                             results_seen, act, faults, judged_out);
                return;
            end
            v = verdicts_due.pop_front();
            if (act !== v.act || faults !== v.faults || judged_out !== v.judged)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d mismatch: action exp %0d got %0d, %s %0d got %0d, %s",
                             results_seen, v.act, act, "faults_seen exp", v.faults, faults,
                             $sformatf("last_judged_entries exp %0d got %0d",
                                       v.judged, judged_out));
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction
    endclass

    storm_verdict_board verdicts = new();

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [prsg_pkg::TIME_W-1:0]    now_ms = '0;
    logic [prsg_pkg::COUNT_W-1:0]   entry_count = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [prsg_pkg::ACT_W-1:0]     action;
    logic [prsg_pkg::COUNT_W-1:0]   faults_seen;
    logic [prsg_pkg::COUNT_W-1:0]   last_judged_entries;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [prsg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data = '0;

    // stimulus-side mirror of the settings, used only to shape poll spacing and entry steps
    logic [prsg_pkg::WIN_W-1:0]     cfg_win = prsg_pkg::WINDOW_LENGTH_RST;
    logic [prsg_pkg::COUNT_W-1:0]   cfg_max = prsg_pkg::MAX_ENTRIES_RST;
    // last poll sent, for relative stepping
    logic [prsg_pkg::TIME_W-1:0]    poll_t = '0;
    logic [prsg_pkg::COUNT_W-1:0]   poll_n = '0;

    // 0 disables idling; otherwise a gap is drawn with chance 1 in idle_rate+1
    int unsigned          idle_rate = 0;
    int unsigned          rx_hold = 0;
    bit                   long_hold_req = 1'b0;
    bit                   long_hold_done = 1'b0;

    pulse_rate_storm_guard dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .now_ms              (now_ms),
        .entry_count         (entry_count),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .action              (action),
        .faults_seen         (faults_seen),
        .last_judged_entries (last_judged_entries),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: every transfer is seen here, at the edge where it happens.
    // The result is checked before the poll on the same edge is predicted;
    // that poll can never be the source of this result.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            verdicts.judge_result(action, faults_seen, last_judged_entries);
        if (in_valid && in_ready)
            verdicts.take_poll(now_ms, entry_count);
        if (cfg_valid && cfg_ready)
            verdicts.set_reg(cfg_index, cfg_data);
    end

    // Result receiver: random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            rx_hold        <= RECEIVER_HOLD_CYCLES - 1;
            out_ready      <= 1'b0;
        end
        else if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0)
        begin
            rx_hold   <= $urandom_range(0, 17);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Offer one poll and hold it until transfer. Valid is left high, unless a random
    // gap is drawn, so a back-to-back poll can follow; the caller drops it at the end of a run.
    task automatic send_poll(input logic [prsg_pkg::TIME_W-1:0] t,
                             input logic [prsg_pkg::COUNT_W-1:0] n);
        in_valid    <= 1'b1;
        now_ms      <= t;
        entry_count <= n;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        poll_t = t;
        poll_n = n;
        if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic poll_rel(input logic [prsg_pkg::TIME_W-1:0] dt,
                            input logic [prsg_pkg::COUNT_W-1:0] dn);
        send_poll(poll_t + dt, poll_n + dn);
    endtask

    task automatic write_reg(input logic [prsg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    // Wait for every owed verdict, then let any in-flight work finish
    task automatic settle();
        while (verdicts.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Polls spaced around the window edges, with entry deltas bunched around
    // the scaled allowance; a share of fully random steps acts as noise.
    task automatic storm_polls(input int unsigned n);
        int unsigned                  w;
        logic [prsg_pkg::TIME_W-1:0]  dt;
        logic [prsg_pkg::COUNT_W-1:0] dn;
        logic [63:0]                  allow;
        w = (cfg_win == '0) ? 1 : cfg_win;
        for (int unsigned i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:       dt = $urandom_range(0, w - 1);
                2, 3, 4, 5: dt = w + $urandom_range(0, w);
                6:          dt = $urandom_range(w, WINDOW_STALL_FACTOR * w);
                7:          dt = WINDOW_STALL_FACTOR * w + $urandom_range(0, 1);
                8:          dt = $urandom_range(WINDOW_STALL_FACTOR * w + 1, 40 * w);
                default:    dt = $urandom();
            endcase
            allow = (64'(cfg_max) * 64'(dt)) / 64'(w);
            if (allow > 64'(32'hFFFF_FFFF))
                dn = $urandom();
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: dn = allow[31:0] - 1 + $urandom_range(0, 2);
                    4, 5:       dn = $urandom_range(0, allow[31:0]);
                    6, 7:       dn = allow[31:0] + 1 + $urandom_range(0, 50);
                    8:          dn = $urandom();
                    default:    dn = '0;
                endcase
            end
            poll_rel(dt, dn);
        end
        in_valid <= 1'b0;
    endtask

    // One setting of the registers, written while idle, then a run of polls
    task automatic run_phase(input logic [31:0] win_word, input logic [31:0] quiet,
                             input logic [31:0] max_n, input int unsigned rate,
                             input bit squeeze, input int unsigned n);
        settle();
        write_reg(prsg_pkg::CFG_WINDOW_LENGTH, win_word);
        write_reg(prsg_pkg::CFG_QUIET_TIME, quiet);
        write_reg(prsg_pkg::CFG_MAX_ENTRIES, max_n);
        write_reg(CFG_UNMAPPED, $urandom());
        cfg_valid <= 1'b0;
        cfg_win   = win_word[prsg_pkg::WIN_W-1:0];
        cfg_max   = max_n;
        idle_rate = rate;
        if (squeeze)
            long_hold_req <= 1'b1;
        storm_polls(n);
    endtask

    initial
    begin
        int unsigned w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence at the reset settings: 100 ms window, 1000 quiet,
        // 1000 entries per window
        idle_rate = 2;
        send_poll(32'hFFFF_FFF0, 32'hFFFF_FF00);   // seeds only, near the wrap
        poll_rel(50, 0);                           // window still open
        poll_rel(50, 1000);                        // exactly one window, delta at limit
        poll_rel(1000, 10001);                     // ten windows, one over: detach
        poll_rel(999, 5);                          // still cooling down
        poll_rel(1, 7);                            // quiet time reached: reattach
        poll_rel(1001, 3);                         // past ten windows: discarded
        poll_rel(100, 0);                          // judged with zero entries
        poll_rel(150, 1500);                       // scaled allowance met exactly
        poll_rel(150, 1501);                       // one over scaled allowance
        send_poll(32'h0, 32'h0);                   // far jump clears the fault
        send_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // huge elapsed: discarded
        send_poll(32'h0, 32'h0);                   // time wraps, 1 ms in
        poll_rel(99, 32'hFFFF_FFFE);               // full-range delta: detach
        poll_rel(500, 1);
        poll_rel(500, 1);                          // reattach
        in_valid <= 1'b0;

        // zero window (high data bits set, must be ignored), zero quiet, zero allowance
        run_phase(32'hABCD_0000, 32'd0, 32'd0, 3, 1'b0, 100);
        // every register at its top value
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 60);
        // smallest window, with the long receiver hold-off
        run_phase(32'h0000_0001, 32'd5, 32'd1, 1, 1'b1, 120);
        for (int k = 0; k < 5; k++)
        begin
            w = $urandom_range(1, 3000);
            run_phase({16'($urandom()), 16'(w)},
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20 * w),
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4 * w),
                      $urandom_range(0, 6), 1'b0, 100);
        end
        // back to the reset settings, full speed on both sides
        run_phase(32'd100, 32'd1000, 32'd1000, 0, 1'b0, 120);

        settle();
        if (verdicts.mismatches == 0 && verdicts.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: a run of cycles with no transfer on any channel means a hang
    initial
    begin
        int unsigned stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: pulse_rate_storm_guard.f
rtl/prsg_pkg.sv
rtl/prsg_mul.sv
rtl/pulse_rate_storm_guard.sv
dv/tb_pulse_rate_storm_guard.sv
